/* rtl/stats_batch_record_checker_defines.svh */
// Assertion macros shared by the batch record checker RTL.
`ifndef STATS_BATCH_RECORD_CHECKER_DEFINES_SVH
`define STATS_BATCH_RECORD_CHECKER_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define SBRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SBRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sbrc_pkg.sv */
// Types, constants and helper functions of the batch record checker.
package sbrc_pkg;

	localparam int MAX_EVENT_COUNT = 64;
	localparam int HDR_LEN = 54;
	localparam int EV_LEN = 28;
	localparam int TRAILER_LEN = 4;
	localparam int POS_CAP = HDR_LEN + MAX_EVENT_COUNT * EV_LEN + TRAILER_LEN + 1;
	localparam int MAX_HDR_COUNT = 255;

	localparam int POS_W = $clog2(POS_CAP + 1);
	localparam int EV_END_W = $clog2(HDR_LEN + MAX_HDR_COUNT * EV_LEN + TRAILER_LEN + 1);
	localparam int OFF_W = $clog2(EV_LEN);
	localparam int IDX_W = 6;
	localparam int TOTAL_W = 7;

	localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
	localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
	localparam logic [7:0] HDR_VERSION = 8'd1;
	localparam logic [7:0] MAGIC [4] = '{8'h52, 8'h53, 8'h54, 8'h41};

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_HEADER   = 3'd1,
		ST_BAD_LENGTH   = 3'd2,
		ST_BAD_IDENTITY = 3'd3,
		ST_BAD_EPOCH    = 3'd4,
		ST_BAD_EVENT    = 3'd5,
		ST_BAD_CRC      = 3'd6
	} status_t;

	typedef enum logic {
		RK_EVENT  = 1'b0,
		RK_STATUS = 1'b1
	} result_kind_t;

	typedef struct packed {
		result_kind_t       kind;
		status_t            status;
		logic [IDX_W-1:0]   event_index;
		logic [63:0]        start_ms;
		logic [62:0]        epoch_seconds;
		logic [31:0]        page;
		logic [31:0]        total_pages;
		logic [31:0]        duration;
		logic [TOTAL_W-1:0] event_total;
	} result_t;

	typedef struct packed {
		logic [63:0] start_ms;
		logic [62:0] epoch_seconds;
		logic [31:0] page;
		logic [31:0] total_pages;
		logic [31:0] duration;
		logic        epoch_bad;
		logic        invalid;
	} ev_check_t;

	function automatic logic lower_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66);
	endfunction

	// Reflected CRC-32, one byte folded in bit by bit.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

/* rtl/sbrc_rec_if.sv */
// Byte stream channel into the batch record checker.
interface sbrc_rec_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_record;

	modport source (output valid, output data_byte, output end_of_record, input ready);
	modport sink (input valid, input data_byte, input end_of_record, output ready);
endinterface

/* rtl/sbrc_res_if.sv */
// Result channel out of the batch record checker.
interface sbrc_res_if;
	import sbrc_pkg::*;

	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [2:0]         status;
	logic [IDX_W-1:0]   event_index;
	logic [63:0]        start_ms;
	logic [62:0]        epoch_seconds;
	logic [31:0]        page;
	logic [31:0]        total_pages;
	logic [31:0]        duration;
	logic [TOTAL_W-1:0] event_total;

	modport source (output valid, output result_kind, output status, output event_index,
		output start_ms, output epoch_seconds, output page, output total_pages,
		output duration, output event_total, input ready);
	modport sink (input valid, input result_kind, input status, input event_index,
		input start_ms, input epoch_seconds, input page, input total_pages,
		input duration, input event_total, output ready);
endinterface

/* rtl/stats_batch_record_checker.sv */
// Top level of the batch record checker: byte stream in, events and status out.
`include "stats_batch_record_checker_defines.svh"

// Batch record checker. Feed a record one byte per transfer on rec, with
// end_of_record set on its final byte. The record is a 54-byte header ("RSTA",
// version 1, an event count of 1 to 64, 48 lowercase hex identity characters),
// the 28-byte little-endian events and a 4-byte little-endian CRC-32 over
// header and events. Each valid event goes out on res as a result of kind 0 in
// the cycle after its last byte is processed, until the first error is seen.
// The final byte yields one result of kind 1 whose status is 0 only for a
// fully valid record; discard all events of the record unless it is 0. An
// event that ends on the final byte is reported as a wrong length. After the
// status the block is ready for the next record without any gap.
// Rate: one byte per cycle, sustained while res.ready stays high. A byte waits
// in the input register, where its CRC step, header check and event check are
// done; the outcome lands in the result register as the byte leaves the input
// register. A result waiting on res holds the input register, and with it rec,
// until that result is taken.
module stats_batch_record_checker (
	input  logic      clk,
	input  logic      arst_n,
	sbrc_rec_if.sink  rec,
	sbrc_res_if.source res
);
	import sbrc_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	// Record state.
	logic [POS_W-1:0] pos_q;
	logic [7:0]       hc_q;
	logic [31:0]      crc_q;
	logic [31:0]      trailer_q;
	status_t          first_error_q;
	logic [OFF_W-1:0] off_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       ev_bytes_q [EV_LEN-1];

	// Result register.
	logic    res_valid_q;
	result_t res_q;

	// Per-byte decisions.
	logic [7:0]          hc_nx;
	logic [EV_END_W-1:0] ev_end_nx;
	logic [EV_END_W-1:0] pos_ext;
	logic                in_body;
	logic                in_event;
	logic                ev_done;
	status_t             err_hdr;
	status_t             err_ev;
	status_t             first_error_nx;
	logic [31:0]         crc_nx;
	logic [31:0]         trailer_nx;
	logic [POS_W-1:0]    pos_nx;
	logic                emit_ev;
	logic                produce;
	logic [EV_LEN*8-1:0] ev_vec;
	ev_check_t           chk;
	result_t             res_nx;

	// Take a byte whenever the input register is empty or empties in this cycle.
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign rec.ready = !valid_s1 || !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rec.valid && rec.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec.valid && rec.ready) begin
			byte_s1 <= rec.data_byte;
			last_s1 <= rec.end_of_record;
		end
	end

	// Assemble the current event: stored bytes plus the byte in flight.
	always_comb begin
		for (int i = 0; i < EV_LEN - 1; i++) begin
			ev_vec[i*8 +: 8] = ev_bytes_q[i];
		end
		ev_vec[(EV_LEN-1)*8 +: 8] = byte_s1;
	end

	sbrc_event_check u_event_check (
		.ev_bytes (ev_vec),
		.chk      (chk)
	);

	always_comb begin
		// Header checks by byte position; the count byte lands in hc_nx.
		hc_nx   = hc_q;
		err_hdr = ST_OK;
		if (pos_q < POS_W'(4)) begin
			if (byte_s1 != MAGIC[pos_q[1:0]]) err_hdr = ST_BAD_HEADER;
		end else if (pos_q == POS_W'(4)) begin
			if (byte_s1 != HDR_VERSION) err_hdr = ST_BAD_HEADER;
		end else if (pos_q == POS_W'(5)) begin
			hc_nx = byte_s1;
			if (byte_s1 == 8'd0 || byte_s1 > 8'(MAX_EVENT_COUNT)) err_hdr = ST_BAD_HEADER;
		end else if (pos_q < POS_W'(HDR_LEN)) begin
			if (!lower_hex(byte_s1)) err_hdr = ST_BAD_IDENTITY;
		end

		ev_end_nx = EV_END_W'(HDR_LEN) + EV_END_W'(hc_nx) * EV_END_W'(EV_LEN);
		pos_ext   = EV_END_W'(pos_q);
		in_body   = (pos_q < POS_W'(HDR_LEN)) || (pos_ext < ev_end_nx);
		in_event  = (pos_q >= POS_W'(HDR_LEN)) && (pos_ext < ev_end_nx);

		// CRC over header and events, everything after that is trailer.
		crc_nx     = in_body ? crc_byte(crc_q, byte_s1) : crc_q;
		trailer_nx = in_body ? trailer_q : {byte_s1, trailer_q[31:8]};

		// Check an event on its last byte, only while the record is clean.
		ev_done = in_event && (off_q == OFF_W'(EV_LEN - 1)) && (first_error_q == ST_OK);
		err_ev  = ST_OK;
		if (ev_done) begin
			if (chk.epoch_bad) err_ev = ST_BAD_EPOCH;
			else if (chk.invalid) err_ev = ST_BAD_EVENT;
		end

		// Keep the first error in stream order.
		first_error_nx = first_error_q;
		if (first_error_nx == ST_OK) first_error_nx = err_hdr;
		if (first_error_nx == ST_OK) first_error_nx = err_ev;

		pos_nx = (pos_q == POS_W'(POS_CAP)) ? pos_q : pos_q + POS_W'(1);

		emit_ev = ev_done && (err_ev == ST_OK) && !last_s1;
		produce = emit_ev || last_s1;

		// Result payload: an event, or the final status which replaces it.
		res_nx = '0;
		if (last_s1) begin
			res_nx.kind = RK_STATUS;
			if (pos_nx < POS_W'(HDR_LEN) || first_error_nx == ST_BAD_HEADER) begin
				res_nx.status = ST_BAD_HEADER;
			end else begin
				res_nx.event_total = hc_nx[TOTAL_W-1:0];
				if (EV_END_W'(pos_nx) != ev_end_nx + EV_END_W'(TRAILER_LEN))
					res_nx.status = ST_BAD_LENGTH;
				else if (first_error_nx != ST_OK)
					res_nx.status = first_error_nx;
				else if (trailer_nx != (crc_nx ^ CRC_INIT))
					res_nx.status = ST_BAD_CRC;
				else
					res_nx.status = ST_OK;
			end
		end else begin
			res_nx.kind          = RK_EVENT;
			res_nx.status        = ST_OK;
			res_nx.event_index   = idx_q;
			res_nx.start_ms      = chk.start_ms;
			res_nx.epoch_seconds = chk.epoch_seconds;
			res_nx.page          = chk.page;
			res_nx.total_pages   = chk.total_pages;
			res_nx.duration      = chk.duration;
		end
	end

	// Record state: advance per byte, return to reset after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			hc_q          <= '0;
			crc_q         <= CRC_INIT;
			first_error_q <= ST_OK;
			off_q         <= '0;
			idx_q         <= '0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q         <= '0;
				hc_q          <= '0;
				crc_q         <= CRC_INIT;
				first_error_q <= ST_OK;
				off_q         <= '0;
				idx_q         <= '0;
			end else begin
				pos_q         <= pos_nx;
				hc_q          <= hc_nx;
				crc_q         <= crc_nx;
				first_error_q <= first_error_nx;
				if (in_event) begin
					if (off_q == OFF_W'(EV_LEN - 1)) begin
						off_q <= '0;
						idx_q <= idx_q + IDX_W'(1);
					end else begin
						off_q <= off_q + OFF_W'(1);
					end
				end
			end
		end
	end

	// Event bytes and trailer need no reset: every read follows its write.
	always_ff @(posedge clk) begin
		if (advance) begin
			trailer_q <= trailer_nx;
			if (in_event && off_q != OFF_W'(EV_LEN - 1)) begin
				ev_bytes_q[off_q] <= byte_s1;
			end
		end
	end

	// Result register: hold until the transfer on res.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && produce) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			res_q <= res_nx;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.result_kind   = res_q.kind;
	assign res.status        = res_q.status;
	assign res.event_index   = res_q.event_index;
	assign res.start_ms      = res_q.start_ms;
	assign res.epoch_seconds = res_q.epoch_seconds;
	assign res.page          = res_q.page;
	assign res.total_pages   = res_q.total_pages;
	assign res.duration      = res_q.duration;
	assign res.event_total   = res_q.event_total;

	`SBRC_ASSERT(a_counters_in_range, pos_q <= POS_W'(POS_CAP) && off_q < OFF_W'(EV_LEN), "byte position or event offset out of range")
	`SBRC_ASSERT_NEXT(a_reset_after_last, advance && last_s1, pos_q == '0 && first_error_q == ST_OK && crc_q == CRC_INIT, "record state not cleared after final byte")
	`SBRC_ASSERT_NEXT(a_event_only_clean, advance && emit_ev, first_error_q == ST_OK && res_valid_q, "event emitted from a record with an error")
	`SBRC_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(byte_s1) && $stable(last_s1), "input register lost a byte")
	`SBRC_ASSERT(a_event_shape, !(res_valid_q && res_q.kind == RK_EVENT) || (res_q.status == ST_OK && res_q.event_total == '0), "event result carries status fields")

endmodule

/* rtl/sbrc_event_check.sv */
// Little-endian decode and field checks of one 28-byte event.
module sbrc_event_check (
	input  logic [sbrc_pkg::EV_LEN*8-1:0] ev_bytes,
	output sbrc_pkg::ev_check_t           chk
);
	import sbrc_pkg::*;

	logic [63:0] epoch_raw;

	always_comb begin
		epoch_raw         = ev_bytes[127:64];
		chk.start_ms      = ev_bytes[63:0];
		chk.epoch_seconds = epoch_raw[62:0];
		chk.page          = ev_bytes[159:128];
		chk.total_pages   = ev_bytes[191:160];
		chk.duration      = ev_bytes[223:192];
		chk.epoch_bad     = epoch_raw[63];
		chk.invalid       = (chk.total_pages == '0) || (chk.page > chk.total_pages)
			|| (chk.duration == '0);
	end
endmodule
